@@ hdl/assert_macros.svh @@
// assertion helpers for the rtl
// each check is clocked and held off while reset is asserted
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FSC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define FSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FSC_ASSERT(lbl, clk, rstn, prop, msg)
`define FSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

@@ hdl/fsc_pkg.sv @@
// ----------------------------------------------------------------------------
// fsc_pkg
// shared constants, types and the plane generator state for the sphere culler
// ----------------------------------------------------------------------------
package fsc_pkg;

    localparam int COORD_WIDTH      = 24;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int RADIUS_WIDTH     = 23;
    localparam int PLANE_COUNT      = 6;
    localparam int PLANE_IDX_W      = 3;
    localparam int ROW_COUNT        = 4;
    localparam int ROW_W            = 64;
    localparam int ENTRY_W          = 16;
    localparam int ENTRY_FRAC_BITS  = 8;
    localparam int ROW_SEL_W        = 2;
    localparam int PADDR_W          = 5;

    localparam int TERM_W   = ENTRY_W + 1;
    localparam int SQ_W     = 2 * TERM_W;
    localparam int SUMSQ_W  = SQ_W + 2;
    localparam int ROOT_W   = SUMSQ_W / 2;
    localparam int SQREM_W  = ROOT_W + 3;
    localparam int DIVN_W   = TERM_W + NORMAL_FRAC_BITS + 2;
    localparam int DIVR_W   = ROOT_W + 1;
    localparam int COEF_W   = NORMAL_FRAC_BITS + 18;
    localparam int PROD_W   = COEF_W + COORD_WIDTH;
    localparam int DOT_W    = PROD_W + 2;
    localparam int STEP_W   = $clog2(DIVN_W);

    localparam logic [PLANE_IDX_W-1:0] PLANE_NONE = PLANE_IDX_W'(PLANE_COUNT);
    localparam logic [PLANE_IDX_W-1:0] PLANE_LAST = PLANE_IDX_W'(PLANE_COUNT - 1);

    localparam logic [ROW_W-1:0] ROW0_RESET = 64'h0000_0000_0000_0100;
    localparam logic [ROW_W-1:0] ROW1_RESET = 64'h0000_0000_0100_0000;
    localparam logic [ROW_W-1:0] ROW2_RESET = 64'h0000_0100_0000_0000;
    localparam logic [ROW_W-1:0] ROW3_RESET = 64'h0100_0000_0000_0000;

    // coefficient slots within a plane
    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;
    localparam logic [1:0] COMP_D = 2'd3;

    typedef struct packed {
        logic signed [COEF_W-1:0] nx;
        logic signed [COEF_W-1:0] ny;
        logic signed [COEF_W-1:0] nz;
        logic signed [COEF_W-1:0] nd;
    } plane_t;

    typedef plane_t [PLANE_COUNT-1:0] plane_set_t;

    typedef logic [ROW_COUNT-1:0][ROW_W-1:0] matrix_t;

    typedef enum logic [2:0] {
        PG_TERMS,
        PG_SQUARE,
        PG_SQRT,
        PG_DIVIDE,
        PG_DONE
    } plane_gen_state_t;

endpackage

@@ hdl/frustum_sphere_cull.sv @@
// ----------------------------------------------------------------------------
// frustum_sphere_cull
// sphere against view frustum test with planes taken from a matrix
// ----------------------------------------------------------------------------
// usage
//   configuration: apb port, four 64-bit matrix rows at byte offsets 0, 8,
//   16 and 24, four signed q8.8 entries each, column 0 in the low bits.
//   a row write restarts plane derivation; in_ready stays low until the
//   planes are set (six planes, each a term load, a square sum, a square
//   root and four serial divides, the divides skipped for a zero normal,
//   then ready is raised).
//   input channel: in_valid/in_ready with center_x/y/z and sphere_radius.
//   output channel: out_valid/out_ready with inside_res and culling_plane.
//   out_valid follows the three stages (input, product, verdict); one item is
//   taken per cycle while the planes are set and the output is not stalled.
//   reset loads the identity matrix and runs the same plane derivation
//   before the first item is taken.
//   when out_ready is low the stages fill behind the result register and
//   in_ready drops once all three hold an item; nothing is dropped.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module frustum_sphere_cull (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [fsc_pkg::PADDR_W-1:0]            paddr,
    input  logic [fsc_pkg::ROW_W-1:0]              pwdata,
    output logic [fsc_pkg::ROW_W-1:0]              prdata,
    output logic                                   pready,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [fsc_pkg::COORD_WIDTH-1:0] center_x,
    input  logic signed [fsc_pkg::COORD_WIDTH-1:0] center_y,
    input  logic signed [fsc_pkg::COORD_WIDTH-1:0] center_z,
    input  logic [fsc_pkg::RADIUS_WIDTH-1:0]       sphere_radius,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic                                   inside_res,
    output logic [fsc_pkg::PLANE_IDX_W-1:0]        culling_plane
);

    fsc_pkg::matrix_t              rows_reg;
    fsc_pkg::plane_set_t           planes;
    logic                          planes_ready;
    logic                          cfg_wr;
    logic [fsc_pkg::ROW_SEL_W-1:0] cfg_sel;
    logic                          stage_free;
    logic                          take;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_sel = paddr[fsc_pkg::PADDR_W-1 -: fsc_pkg::ROW_SEL_W];
    assign prdata  = rows_reg[cfg_sel];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg[0] <= fsc_pkg::ROW0_RESET;
            rows_reg[1] <= fsc_pkg::ROW1_RESET;
            rows_reg[2] <= fsc_pkg::ROW2_RESET;
            rows_reg[3] <= fsc_pkg::ROW3_RESET;
        end
        else if (cfg_wr)
        begin
            rows_reg[cfg_sel] <= pwdata;
        end
    end

    fsc_plane_gen u_plane_gen (
        .clk          (clk),
        .rst_n        (rst_n),
        .restart      (cfg_wr),
        .rows         (rows_reg),
        .planes       (planes),
        .planes_ready (planes_ready)
    );

    assign in_ready = stage_free && planes_ready;
    assign take     = in_valid && in_ready;

    fsc_cull_pipe u_cull_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .planes     (planes),
        .take       (take),
        .cx         (center_x),
        .cy         (center_y),
        .cz         (center_z),
        .rad        (sphere_radius),
        .stage_free (stage_free),
        .res_valid  (out_valid),
        .res_ready  (out_ready),
        .res_inside (inside_res),
        .res_plane  (culling_plane)
    );

    `FSC_ASSERT(a_verdict_match, clk, rst_n, !out_valid || (inside_res == (culling_plane == fsc_pkg::PLANE_NONE)), "inside flag disagrees with culling plane")
    `FSC_ASSERT(a_plane_range, clk, rst_n, !out_valid || (culling_plane <= fsc_pkg::PLANE_NONE), "culling plane out of range")
    `FSC_ASSERT_NEXT(a_cfg_blocks, clk, rst_n, cfg_wr, !in_ready, "items taken while planes are rebuilt")

endmodule

@@ hdl/fsc_plane_gen.sv @@
// ----------------------------------------------------------------------------
// fsc_plane_gen
// derives the six normalized clip planes from the matrix rows, using one
// squarer, a bit-serial square root and a bit-serial divider
// ----------------------------------------------------------------------------
module fsc_plane_gen (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                restart,
    input  fsc_pkg::matrix_t    rows,
    output fsc_pkg::plane_set_t planes,
    output logic                planes_ready
);

    fsc_pkg::plane_gen_state_t st_reg, st_next;

    logic [fsc_pkg::PLANE_IDX_W-1:0]        plane_reg, plane_next;
    logic [1:0]                             comp_reg, comp_next;
    logic [fsc_pkg::STEP_W-1:0]             step_reg, step_next;
    logic signed [fsc_pkg::TERM_W-1:0]      term_reg [4];
    logic signed [fsc_pkg::TERM_W-1:0]      term_calc [4];
    logic                                   term_load;
    logic [fsc_pkg::SUMSQ_W-1:0]            sumsq_reg, sumsq_next;
    logic [fsc_pkg::SQREM_W-1:0]            sqrem_reg, sqrem_next;
    logic [fsc_pkg::ROOT_W-1:0]             root_reg, root_next;
    logic [fsc_pkg::ROOT_W-1:0]             len_reg, len_next;
    logic [fsc_pkg::DIVN_W-1:0]             divn_reg, divn_next;
    logic [fsc_pkg::DIVR_W-1:0]             divr_reg, divr_next;
    fsc_pkg::plane_set_t                    planes_reg, planes_next;
    logic                                   ready_reg, ready_next;

    logic [fsc_pkg::ROW_SEL_W-1:0]          src_row;
    logic signed [fsc_pkg::TERM_W-1:0]      e3, es;
    logic signed [fsc_pkg::SQ_W-1:0]        sq;
    logic [fsc_pkg::SQREM_W-1:0]            sq_sh, sq_trial;
    logic [fsc_pkg::DIVR_W:0]               dv_sh, dv_div;
    logic                                   qbit;
    logic signed [fsc_pkg::TERM_W-1:0]      div_term;
    logic [fsc_pkg::TERM_W-1:0]             div_mag;
    logic [1:0]                             div_comp;
    logic [fsc_pkg::ROOT_W-1:0]             div_len;
    logic signed [fsc_pkg::COEF_W-1:0]      coef;

    // raw plane terms: row 3 plus or minus the selected row
    always_comb
    begin
        src_row = plane_reg[fsc_pkg::PLANE_IDX_W-1:1];
        for (int c = 0; c < 4; c++)
        begin
            e3 = fsc_pkg::TERM_W'($signed(rows[3][c*fsc_pkg::ENTRY_W +: fsc_pkg::ENTRY_W]));
            es = fsc_pkg::TERM_W'($signed(rows[src_row][c*fsc_pkg::ENTRY_W +: fsc_pkg::ENTRY_W]));
            term_calc[c] = plane_reg[0] ? (e3 - es) : (e3 + es);
        end
    end

    assign sq      = term_reg[comp_reg] * term_reg[comp_reg];
    assign sq_sh   = {sqrem_reg[fsc_pkg::SQREM_W-3:0],
                      sumsq_reg[fsc_pkg::SUMSQ_W-1 -: 2]};
    assign sq_trial = fsc_pkg::SQREM_W'({root_reg, 2'b01});

    assign dv_sh  = {divr_reg, divn_reg[fsc_pkg::DIVN_W-1]};
    assign dv_div = {1'b0, len_reg, 1'b0};
    assign qbit   = (dv_sh >= dv_div);

    always_comb
    begin
        st_next     = st_reg;
        plane_next  = plane_reg;
        comp_next   = comp_reg;
        step_next   = step_reg;
        sumsq_next  = sumsq_reg;
        sqrem_next  = sqrem_reg;
        root_next   = root_reg;
        len_next    = len_reg;
        divn_next   = divn_reg;
        divr_next   = divr_reg;
        planes_next = planes_reg;
        ready_next  = ready_reg;
        term_load   = 1'b0;
        div_comp    = comp_reg;
        div_len     = len_reg;
        coef        = '0;
        div_term    = '0;
        div_mag     = '0;

        unique case (st_reg)
            fsc_pkg::PG_TERMS:
            begin
                term_load  = 1'b1;
                sumsq_next = '0;
                comp_next  = fsc_pkg::COMP_X;
                st_next    = fsc_pkg::PG_SQUARE;
            end
            fsc_pkg::PG_SQUARE:
            begin
                sumsq_next = sumsq_reg + fsc_pkg::SUMSQ_W'(unsigned'(sq));
                comp_next  = comp_reg + 2'd1;
                if (comp_reg == fsc_pkg::COMP_Z)
                begin
                    step_next  = '0;
                    sqrem_next = '0;
                    root_next  = '0;
                    st_next    = fsc_pkg::PG_SQRT;
                end
            end
            fsc_pkg::PG_SQRT:
            begin
                sumsq_next = sumsq_reg << 2;
                if (sq_sh >= sq_trial)
                begin
                    sqrem_next = sq_sh - sq_trial;
                    root_next  = {root_reg[fsc_pkg::ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    sqrem_next = sq_sh;
                    root_next  = {root_reg[fsc_pkg::ROOT_W-2:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == fsc_pkg::STEP_W'(fsc_pkg::ROOT_W - 1))
                begin
                    len_next = root_next;
                    if (root_next == '0)
                    begin
                        // degenerate normal: zero normal, length taken as one
                        planes_next[plane_reg].nx = '0;
                        planes_next[plane_reg].ny = '0;
                        planes_next[plane_reg].nz = '0;
                        planes_next[plane_reg].nd =
                            fsc_pkg::COEF_W'(term_reg[3])
                            <<< (fsc_pkg::NORMAL_FRAC_BITS - fsc_pkg::ENTRY_FRAC_BITS);
                        plane_next = plane_reg + 1'b1;
                        st_next    = (plane_reg == fsc_pkg::PLANE_LAST) ?
                                     fsc_pkg::PG_DONE : fsc_pkg::PG_TERMS;
                    end
                    else
                    begin
                        div_comp = fsc_pkg::COMP_X;
                        div_len  = root_next;
                        st_next  = fsc_pkg::PG_DIVIDE;
                    end
                end
            end
            fsc_pkg::PG_DIVIDE:
            begin
                divr_next = qbit ? fsc_pkg::DIVR_W'(dv_sh - dv_div)
                                 : fsc_pkg::DIVR_W'(dv_sh);
                divn_next = {divn_reg[fsc_pkg::DIVN_W-2:0], qbit};
                step_next = step_reg + 1'b1;
                if (step_reg == fsc_pkg::STEP_W'(fsc_pkg::DIVN_W - 1))
                begin
                    coef = term_reg[comp_reg][fsc_pkg::TERM_W-1] ?
                           -fsc_pkg::COEF_W'(divn_next) : fsc_pkg::COEF_W'(divn_next);
                    unique case (comp_reg)
                        fsc_pkg::COMP_X: planes_next[plane_reg].nx = coef;
                        fsc_pkg::COMP_Y: planes_next[plane_reg].ny = coef;
                        fsc_pkg::COMP_Z: planes_next[plane_reg].nz = coef;
                        default:         planes_next[plane_reg].nd = coef;
                    endcase
                    if (comp_reg == fsc_pkg::COMP_D)
                    begin
                        plane_next = plane_reg + 1'b1;
                        st_next    = (plane_reg == fsc_pkg::PLANE_LAST) ?
                                     fsc_pkg::PG_DONE : fsc_pkg::PG_TERMS;
                    end
                    else
                    begin
                        div_comp = comp_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                ready_next = 1'b1;
            end
        endcase

        // load the divider for the next coefficient
        if (div_comp != comp_reg || (st_reg == fsc_pkg::PG_SQRT && st_next == fsc_pkg::PG_DIVIDE))
        begin
            div_term  = term_reg[div_comp];
            div_mag   = div_term[fsc_pkg::TERM_W-1] ? unsigned'(-div_term) : unsigned'(div_term);
            divn_next = fsc_pkg::DIVN_W'({div_mag, {fsc_pkg::NORMAL_FRAC_BITS{1'b0}}, 1'b0})
                        + fsc_pkg::DIVN_W'(div_len);
            divr_next = '0;
            step_next = '0;
            comp_next = div_comp;
        end

        if (restart)
        begin
            st_next    = fsc_pkg::PG_TERMS;
            plane_next = '0;
            ready_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= fsc_pkg::PG_TERMS;
            plane_reg <= '0;
            comp_reg  <= '0;
            step_reg  <= '0;
            ready_reg <= 1'b0;
        end
        else
        begin
            st_reg    <= st_next;
            plane_reg <= plane_next;
            comp_reg  <= comp_next;
            step_reg  <= step_next;
            ready_reg <= ready_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (term_load)
        begin
            for (int c = 0; c < 4; c++)
            begin
                term_reg[c] <= term_calc[c];
            end
        end
        sumsq_reg  <= sumsq_next;
        sqrem_reg  <= sqrem_next;
        root_reg   <= root_next;
        len_reg    <= len_next;
        divn_reg   <= divn_next;
        divr_reg   <= divr_next;
        planes_reg <= planes_next;
    end

    assign planes       = planes_reg;
    assign planes_ready = ready_reg;

endmodule

@@ hdl/fsc_cull_pipe.sv @@
// ----------------------------------------------------------------------------
// fsc_cull_pipe
// three register stages: input, plane products, plane verdict
// ----------------------------------------------------------------------------
module fsc_cull_pipe (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  fsc_pkg::plane_set_t                    planes,
    input  logic                                   take,
    input  logic signed [fsc_pkg::COORD_WIDTH-1:0] cx,
    input  logic signed [fsc_pkg::COORD_WIDTH-1:0] cy,
    input  logic signed [fsc_pkg::COORD_WIDTH-1:0] cz,
    input  logic [fsc_pkg::RADIUS_WIDTH-1:0]       rad,
    output logic                                   stage_free,
    output logic                                   res_valid,
    input  logic                                   res_ready,
    output logic                                   res_inside,
    output logic [fsc_pkg::PLANE_IDX_W-1:0]        res_plane
);

    logic v0_reg, v1_reg, v2_reg;
    logic adv0, adv1, adv2;

    logic signed [fsc_pkg::COORD_WIDTH-1:0]  x_reg, y_reg, z_reg;
    logic [fsc_pkg::RADIUS_WIDTH-1:0]        r_reg;

    logic signed [fsc_pkg::PROD_W-1:0] px_reg [fsc_pkg::PLANE_COUNT];
    logic signed [fsc_pkg::PROD_W-1:0] py_reg [fsc_pkg::PLANE_COUNT];
    logic signed [fsc_pkg::PROD_W-1:0] pz_reg [fsc_pkg::PLANE_COUNT];
    logic signed [fsc_pkg::DOT_W-1:0]  pd_reg [fsc_pkg::PLANE_COUNT];
    logic signed [fsc_pkg::DOT_W-1:0]  limit_reg;

    logic signed [fsc_pkg::DOT_W-1:0]  dot [fsc_pkg::PLANE_COUNT];
    logic [fsc_pkg::PLANE_COUNT-1:0]   fail;
    logic [fsc_pkg::PLANE_IDX_W-1:0]   plane_next;

    logic                              inside_reg;
    logic [fsc_pkg::PLANE_IDX_W-1:0]   plane_reg;

    assign adv2       = !v2_reg || res_ready;
    assign adv1       = !v1_reg || adv2;
    assign adv0       = !v0_reg || adv1;
    assign stage_free = adv0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (adv0)
            begin
                v0_reg <= take;
            end
            if (adv1)
            begin
                v1_reg <= v0_reg;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv0 && take)
        begin
            x_reg <= cx;
            y_reg <= cy;
            z_reg <= cz;
            r_reg <= rad;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && v0_reg)
        begin
            for (int p = 0; p < fsc_pkg::PLANE_COUNT; p++)
            begin
                px_reg[p] <= fsc_pkg::PROD_W'(planes[p].nx) * fsc_pkg::PROD_W'(x_reg);
                py_reg[p] <= fsc_pkg::PROD_W'(planes[p].ny) * fsc_pkg::PROD_W'(y_reg);
                pz_reg[p] <= fsc_pkg::PROD_W'(planes[p].nz) * fsc_pkg::PROD_W'(z_reg);
                pd_reg[p] <= fsc_pkg::DOT_W'(planes[p].nd) <<< fsc_pkg::ENTRY_FRAC_BITS;
            end
            limit_reg <= -$signed(fsc_pkg::DOT_W'({r_reg,
                                                   {fsc_pkg::NORMAL_FRAC_BITS{1'b0}}}));
        end
    end

    always_comb
    begin
        for (int p = 0; p < fsc_pkg::PLANE_COUNT; p++)
        begin
            dot[p]  = fsc_pkg::DOT_W'(px_reg[p]) + fsc_pkg::DOT_W'(py_reg[p])
                      + fsc_pkg::DOT_W'(pz_reg[p]) + pd_reg[p];
            fail[p] = (dot[p] < limit_reg);
        end
        // first failing plane wins
        plane_next = fsc_pkg::PLANE_NONE;
        for (int p = fsc_pkg::PLANE_COUNT - 1; p >= 0; p--)
        begin
            if (fail[p])
            begin
                plane_next = fsc_pkg::PLANE_IDX_W'(p);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv2 && v1_reg)
        begin
            plane_reg  <= plane_next;
            inside_reg <= (fail == '0);
        end
    end

    assign res_valid  = v2_reg;
    assign res_inside = inside_reg;
    assign res_plane  = plane_reg;

endmodule

@@ tb/frustum_sphere_cull_checker.sv @@
// ----------------------------------------------------------------------------
// frustum_sphere_cull_checker
// watches the config port and both item channels, derives the six clip planes
// from the matrix rows, predicts the cull verdict of every accepted sphere and
// compares it with the results in order
// ----------------------------------------------------------------------------
module frustum_sphere_cull_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic                                   pready,
    input  logic [fsc_pkg::PADDR_W-1:0]            paddr,
    input  logic [fsc_pkg::ROW_W-1:0]              pwdata,
    input  logic                                   in_valid,
    input  logic                                   in_ready,
    input  logic signed [fsc_pkg::COORD_WIDTH-1:0] center_x,
    input  logic signed [fsc_pkg::COORD_WIDTH-1:0] center_y,
    input  logic signed [fsc_pkg::COORD_WIDTH-1:0] center_z,
    input  logic [fsc_pkg::RADIUS_WIDTH-1:0]       sphere_radius,
    input  logic                                   out_valid,
    input  logic                                   out_ready,
    input  logic                                   inside_res,
    input  logic [fsc_pkg::PLANE_IDX_W-1:0]        culling_plane,
    output int                                     errors,
    output int                                     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        longint nx;
        longint ny;
        longint nz;
        longint nd;
    } clip_plane_t;

    typedef struct {
        logic                            in_view;
        logic [fsc_pkg::PLANE_IDX_W-1:0] plane;
    } verdict_t;

    logic [fsc_pkg::ROW_W-1:0] rows [fsc_pkg::ROW_COUNT];
    clip_plane_t               clip [fsc_pkg::PLANE_COUNT];
    verdict_t                  verdict_q [$];

    function automatic longint row_entry(int r, int c);
        return longint'($signed(rows[r][fsc_pkg::ENTRY_W*c +: fsc_pkg::ENTRY_W]));
    endfunction

    function automatic longint unsigned root_floor(longint unsigned s);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'h1 << 62;
        while (b > s)
            b = b >> 2;
        while (b != 0)
        begin
            if (s >= res + b)
            begin
                s = s - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // divide by the normal length, halves rounded away from zero
    function automatic longint scaled_ratio(longint v, longint unsigned len);
        longint unsigned mag;
        longint unsigned q;
        mag = (v < 0) ? longint'(-v) : longint'(v);
        q = (2 * (mag << fsc_pkg::NORMAL_FRAC_BITS) + len) / (2 * len);
        return (v < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic void derive_clip_planes();
        longint          a, b, c, d, sgn;
        longint unsigned len;
        int              src;
        for (int p = 0; p < fsc_pkg::PLANE_COUNT; p++)
        begin
            src = p / 2;
            sgn = (p % 2) ? -1 : 1;
            a = row_entry(3, 0) + sgn * row_entry(src, 0);
            b = row_entry(3, 1) + sgn * row_entry(src, 1);
            c = row_entry(3, 2) + sgn * row_entry(src, 2);
            d = row_entry(3, 3) + sgn * row_entry(src, 3);
            len = root_floor(longint'(a * a + b * b + c * c));
            if (len == 0)
            begin
                // degenerate normal, length taken as one
                clip[p].nx = 0;
                clip[p].ny = 0;
                clip[p].nz = 0;
                clip[p].nd = d * (longint'(1)
                             << (fsc_pkg::NORMAL_FRAC_BITS - fsc_pkg::ENTRY_FRAC_BITS));
            end
            else
            begin
                clip[p].nx = scaled_ratio(a, len);
                clip[p].ny = scaled_ratio(b, len);
                clip[p].nz = scaled_ratio(c, len);
                clip[p].nd = scaled_ratio(d, len);
            end
        end
    endfunction

    function automatic verdict_t cull_sphere(longint x, longint y, longint z,
                                             longint r);
        verdict_t v;
        longint   bound;
        longint   plane_dot;
        bound = -(r << fsc_pkg::NORMAL_FRAC_BITS);
        v.in_view = 1'b1;
        v.plane   = fsc_pkg::PLANE_NONE;
        for (int p = 0; p < fsc_pkg::PLANE_COUNT; p++)
        begin
            plane_dot = clip[p].nx * x + clip[p].ny * y + clip[p].nz * z
                        + clip[p].nd * 256;
            if (plane_dot < bound)
            begin
                v.in_view = 1'b0;
                v.plane   = fsc_pkg::PLANE_IDX_W'(p);
                return v;
            end
        end
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        int       idx;
        if (!rst_n)
        begin
            rows[0] = fsc_pkg::ROW0_RESET;
            rows[1] = fsc_pkg::ROW1_RESET;
            rows[2] = fsc_pkg::ROW2_RESET;
            rows[3] = fsc_pkg::ROW3_RESET;
            derive_clip_planes();
            verdict_q.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                idx = int'(paddr >> 3);
                if (idx < fsc_pkg::ROW_COUNT)
                begin
                    rows[idx] = pwdata;
                    derive_clip_planes();
                end
            end
            if (in_valid && in_ready)
                verdict_q.push_back(cull_sphere(longint'(center_x), longint'(center_y),
                                                longint'(center_z),
                                                longint'({1'b0, sphere_radius})));
            if (out_valid && out_ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    $display("%0t: unexpected item: inside_res %0b culling_plane %0d",
                             $realtime, inside_res, culling_plane);
                    errors <= errors + 1;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (inside_res !== want.in_view)
                    begin
                        $display("%0t: inside_res expected %0b actual %0b",
                                 $realtime, want.in_view, inside_res);
                        errors <= errors + 1;
                    end
                    else if (culling_plane !== want.plane)
                    begin
                        $display("%0t: culling_plane expected %0d actual %0d",
                                 $realtime, want.plane, culling_plane);
                        errors <= errors + 1;
                    end
                end
            end
            pending <= verdict_q.size();
        end
    end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// drives spheres and matrix settings into frustum_sphere_cull with random
// gaps and output stalls; the checker predicts and compares every result
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;
    localparam int PHASE_ITEMS = 150;
    localparam int PHASES = 8;

    logic                                   clk;
    logic                                   rst_n;
    logic                                   psel;
    logic                                   penable;
    logic                                   pwrite;
    logic [fsc_pkg::PADDR_W-1:0]            paddr;
    logic [fsc_pkg::ROW_W-1:0]              pwdata;
    logic [fsc_pkg::ROW_W-1:0]              prdata;
    logic                                   pready;
    logic                                   in_valid;
    logic                                   in_ready;
    logic signed [fsc_pkg::COORD_WIDTH-1:0] center_x;
    logic signed [fsc_pkg::COORD_WIDTH-1:0] center_y;
    logic signed [fsc_pkg::COORD_WIDTH-1:0] center_z;
    logic [fsc_pkg::RADIUS_WIDTH-1:0]       sphere_radius;
    logic                                   out_valid;
    logic                                   out_ready;
    logic                                   inside_res;
    logic [fsc_pkg::PLANE_IDX_W-1:0]        culling_plane;
    int                                     errors;
    int                                     pending;
    int                                     idle_cycles;
    int                                     rx_wait;
    bit                                     tx_calm;
    bit                                     rx_calm;

    frustum_sphere_cull u_top (.*);

    frustum_sphere_cull_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver stalls, drawn once per item
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_wait = 0;
        end
        else
        begin
            if (out_valid && out_ready)
                rx_wait = rx_calm ? 0 : $urandom_range(0, 8);
            if (rx_wait > 0)
            begin
                out_ready <= 1'b0;
                rx_wait--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_row(int idx, logic [fsc_pkg::ROW_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= fsc_pkg::PADDR_W'(idx * 8);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic send_sphere(logic signed [fsc_pkg::COORD_WIDTH-1:0] x,
                               logic signed [fsc_pkg::COORD_WIDTH-1:0] y,
                               logic signed [fsc_pkg::COORD_WIDTH-1:0] z,
                               logic [fsc_pkg::RADIUS_WIDTH-1:0] r);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        center_x      <= x;
        center_y      <= y;
        center_z      <= z;
        sphere_radius <= r;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    function automatic logic signed [fsc_pkg::COORD_WIDTH-1:0] pick_coord();
        unique case ($urandom_range(0, 3))
            0:       return fsc_pkg::COORD_WIDTH'($urandom);
            1:       return fsc_pkg::COORD_WIDTH'(int'($urandom_range(0, 131072)) - 65536);
            default: return fsc_pkg::COORD_WIDTH'(int'($urandom_range(0, 1024)) - 512);
        endcase
    endfunction

    function automatic logic [fsc_pkg::RADIUS_WIDTH-1:0] pick_radius();
        unique case ($urandom_range(0, 3))
            0:       return '0;
            1:       return fsc_pkg::RADIUS_WIDTH'($urandom);
            default: return fsc_pkg::RADIUS_WIDTH'($urandom_range(0, 400));
        endcase
    endfunction

    function automatic logic [fsc_pkg::ROW_W-1:0] pick_row(int kind);
        logic [fsc_pkg::ROW_W-1:0] v;
        for (int c = 0; c < 4; c++)
            unique case (kind)
                0:       v[16*c +: 16] = 16'($urandom);
                1:       v[16*c +: 16] = 16'h7fff;
                2:       v[16*c +: 16] = 16'h8000;
                3:       v[16*c +: 16] = 16'h0000;
                default: v[16*c +: 16] = 16'(int'($urandom_range(0, 1024)) - 512);
            endcase
        return v;
    endfunction

    initial
    begin
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        in_valid      <= 1'b0;
        center_x      <= '0;
        center_y      <= '0;
        center_z      <= '0;
        sphere_radius <= '0;
        tx_calm       = 1'b0;
        rx_calm       = 1'b0;
        rst_n         <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // identity planes: unit cube in q16.8, boundaries at +-256
        send_sphere(0, 0, 0, 0);
        send_sphere(256, 256, 256, 0);
        send_sphere(-256, -256, -256, 0);
        send_sphere(-257, 0, 0, 0);
        send_sphere(257, 0, 0, 0);
        send_sphere(0, -257, 0, 0);
        send_sphere(0, 257, 0, 0);
        send_sphere(0, 0, -257, 0);
        send_sphere(0, 0, 257, 0);
        send_sphere(-300, 0, 0, 44);
        send_sphere(-300, 0, 0, 43);
        send_sphere(24'sh7fffff, 0, 0, 0);
        send_sphere(24'sh800000, 0, 0, 0);
        send_sphere(0, 24'sh7fffff, 24'sh800000, 0);
        send_sphere(24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 23'h7fffff);
        send_sphere(24'sh800000, 24'sh800000, 24'sh800000, 23'h7fffff);
        send_sphere(0, 0, 24'sh800000, 23'h7fffff);
        drain_results();

        // zero normals: all-zero matrix, then w row with negative offset only
        write_row(0, '0);
        write_row(1, '0);
        write_row(2, '0);
        write_row(3, '0);
        send_sphere(24'sh7fffff, 24'sh800000, 0, 0);
        drain_results();
        write_row(3, 64'hff00_0000_0000_0000);
        send_sphere(0, 0, 0, 0);
        send_sphere(0, 0, 0, 23'd65535);
        send_sphere(0, 0, 0, 23'd65536);
        send_sphere(5, 5, 5, 23'h7fffff);
        drain_results();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph > 0)
                for (int r = 0; r < fsc_pkg::ROW_COUNT; r++)
                    write_row(r, pick_row((ph < 4) ? ph : (ph % 2) ? 0 : 4));
            else
            begin
                write_row(0, fsc_pkg::ROW0_RESET);
                write_row(1, fsc_pkg::ROW1_RESET);
                write_row(2, fsc_pkg::ROW2_RESET);
                write_row(3, fsc_pkg::ROW3_RESET);
            end
            tx_calm = (ph % 3 == 1);
            rx_calm = (ph % 4 == 2);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                send_sphere(pick_coord(), pick_coord(), pick_coord(), pick_radius());
                if (ph == 2 && i == PHASE_ITEMS / 2)
                    drain_results();
            end
            drain_results();
        end

        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
